/* rtl/rc5_pkg.sv */
package rc5_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ROW_W     = 4;
  localparam int unsigned NUM_ROWS  = 16;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned PASS_W    = 7;
  localparam int unsigned PASSES    = 96;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0]        cmd_t;

  localparam cmd_t CMD_EXPAND  = 2'd0;
  localparam cmd_t CMD_ENCRYPT = 2'd1;
  localparam cmd_t CMD_DECRYPT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

  localparam word_t MAGIC_P     = 32'hb7e15163;
  localparam word_t MAGIC_Q     = 32'h9e3779b9;
  localparam word_t MAGIC_Q_TWO = 32'h3c6ef372;

  typedef struct packed {
    logic decrypt;
    logic whiten;
  } rnd_ctrl_t;

  function automatic word_t rotl32(input word_t x, input logic [4:0] s);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << s;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t rotr32(input word_t x, input logic [4:0] s);
    logic [2*WORD_W-1:0] t;
    t = {x, x} >> s;
    return t[WORD_W-1:0];
  endfunction

endpackage

/* rtl/rc5_ram.sv */
module rc5_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rc5_round.sv */
module rc5_round (
  input  rc5_pkg::rnd_ctrl_t ctrl_i,
  input  rc5_pkg::word_t     a_i,
  input  rc5_pkg::word_t     b_i,
  input  rc5_pkg::word_t     key_even_i,
  input  rc5_pkg::word_t     key_odd_i,
  output rc5_pkg::word_t     a_o,
  output rc5_pkg::word_t     b_o
);

  rc5_pkg::word_t enc_a;
  rc5_pkg::word_t dec_b;

  assign enc_a = rc5_pkg::rotl32(a_i ^ b_i, b_i[4:0]) + key_even_i;
  assign dec_b = rc5_pkg::rotr32(b_i - key_odd_i, a_i[4:0]) ^ a_i;

  always_comb begin
    unique case ({ctrl_i.decrypt, ctrl_i.whiten})
      2'b01: begin
        a_o = a_i + key_even_i;
        b_o = b_i + key_odd_i;
      end
      2'b00: begin
        a_o = enc_a;
        b_o = rc5_pkg::rotl32(enc_a ^ b_i, enc_a[4:0]) + key_odd_i;
      end
      2'b11: begin
        a_o = a_i - key_even_i;
        b_o = b_i - key_odd_i;
      end
      default: begin
        b_o = dec_b;
        a_o = rc5_pkg::rotr32(a_i - key_even_i, dec_b[4:0]) ^ dec_b;
      end
    endcase
  end

endmodule

/* rtl/rc5_block_cipher.sv */
// RC5-32 block cipher, 16-byte key, ROUNDS rounds.
// Channels: an input request (command_i, word_a_i, word_b_i) and a result
// (result_a_o, result_b_o, status_o), each with valid/ready; a config write
// channel (cfg_index_i, cfg_data_i) that loads key_low (index 0) and key_high
// (index 1). It is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. Round keys live in a
// 16 x 64-bit RAM, one row per round (even and odd key), so encrypt and
// decrypt read one row and run one full round per cycle.
// Expand fills the RAM with the magic sequence, then makes 96 mixing passes,
// each of which reads and updates a round key and then updates a key word.
// A request is taken only when the previous one has left the core; the
// result register lets a new request in while the last result still waits.
// A stalled receiver holds the finished result inside the core until the
// result register frees up. Reset clears the key registers and the
// schedule-valid flag; encrypt or decrypt before any expand returns zero
// words with status 1. Command 3 returns zero words with status 0.
module rc5_block_cipher #(
  parameter int unsigned ROUNDS = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         command_i,
  input  logic [31:0]                        word_a_i,
  input  logic [31:0]                        word_b_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        result_a_o,
  output logic [31:0]                        result_b_o,
  output logic                               status_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rc5_pkg::KEY_W-1:0]          cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(ROUNDS + 1);
  localparam int unsigned RW    = rc5_pkg::ROW_W;
  localparam int unsigned WW    = rc5_pkg::WORD_W;
  localparam int unsigned PW    = rc5_pkg::PASS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_EXP_S,
    ST_EXP_L,
    ST_CRYPT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   sched_valid_q, sched_valid_d;
  rc5_pkg::word_t res_a_q, res_a_d, res_b_q, res_b_d;
  logic   res_stat_q, res_stat_d;
  logic [rc5_pkg::KEY_W-1:0] key_low_q, key_high_q;

  rc5_pkg::word_t a_q, a_d, b_q, b_d;
  rc5_pkg::word_t acc_q, acc_d;
  rc5_pkg::word_t even_q, even_d, odd_q, odd_d;
  rc5_pkg::word_t kw_q [rc5_pkg::KEY_WORDS];
  rc5_pkg::word_t kw_d [rc5_pkg::KEY_WORDS];
  logic [RW-1:0]    row_q, row_d;
  logic [PW-1:0]    pass_q, pass_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic             dec_q, dec_d;
  logic             stat_q, stat_d;

  logic            ram_we, ram_re;
  logic [RW-1:0]   ram_waddr, ram_raddr;
  logic [2*WW-1:0] ram_wdata, ram_rdata;

  rc5_pkg::rnd_ctrl_t rnd_ctrl;
  rc5_pkg::word_t     rnd_a, rnd_b;
  rc5_pkg::word_t     s_old, s_new, ab_sum, l_new;

  rc5_ram #(
    .WIDTH(2 * WW),
    .DEPTH(rc5_pkg::NUM_ROWS)
  ) u_keys (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rnd_ctrl.decrypt = dec_q;
  assign rnd_ctrl.whiten  = dec_q ? (cnt_q == CNT_W'(ROUNDS)) : (cnt_q == '0);

  rc5_round u_round (
    .ctrl_i    (rnd_ctrl),
    .a_i       (a_q),
    .b_i       (b_q),
    .key_even_i(ram_rdata[WW-1:0]),
    .key_odd_i (ram_rdata[2*WW-1:WW]),
    .a_o       (rnd_a),
    .b_o       (rnd_b)
  );

  assign s_old    = pass_q[0] ? odd_q : ram_rdata[WW-1:0];
  assign s_new    = rc5_pkg::rotl32(s_old + a_q + b_q, 5'd3);
  assign ab_sum   = a_q + b_q;
  assign l_new    = rc5_pkg::rotl32(kw_q[pass_q[1:0]] + ab_sum, ab_sum[4:0]);
  assign cnt_next = cnt_q + CNT_W'(1);

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    sched_valid_d = sched_valid_q;
    res_a_d       = res_a_q;
    res_b_d       = res_b_q;
    res_stat_d    = res_stat_q;
    a_d           = a_q;
    b_d           = b_q;
    acc_d         = acc_q;
    even_d        = even_q;
    odd_d         = odd_q;
    kw_d          = kw_q;
    row_d         = row_q;
    pass_d        = pass_q;
    cnt_d         = cnt_q;
    dec_d         = dec_q;
    stat_d        = stat_q;
    ram_we        = 1'b0;
    ram_waddr     = row_q;
    ram_wdata     = {acc_q + rc5_pkg::MAGIC_Q, acc_q};
    ram_re        = 1'b0;
    ram_raddr     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          stat_d = 1'b0;
          a_d    = '0;
          b_d    = '0;
          unique case (command_i)
            rc5_pkg::CMD_EXPAND: begin
              kw_d[0] = key_low_q[WW-1:0];
              kw_d[1] = key_low_q[2*WW-1:WW];
              kw_d[2] = key_high_q[WW-1:0];
              kw_d[3] = key_high_q[2*WW-1:WW];
              acc_d   = rc5_pkg::MAGIC_P;
              row_d   = '0;
              pass_d  = '0;
              state_d = ST_INIT;
            end
            rc5_pkg::CMD_ENCRYPT, rc5_pkg::CMD_DECRYPT: begin
              if (sched_valid_q) begin
                a_d       = word_a_i;
                b_d       = word_b_i;
                dec_d     = (command_i == rc5_pkg::CMD_DECRYPT);
                cnt_d     = '0;
                ram_re    = 1'b1;
                ram_raddr = (command_i == rc5_pkg::CMD_DECRYPT) ? RW'(ROUNDS) : '0;
                state_d   = ST_CRYPT;
              end else begin
                stat_d  = 1'b1;
                state_d = ST_FINISH;
              end
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_INIT: begin
        ram_we = 1'b1;
        acc_d  = acc_q + rc5_pkg::MAGIC_Q_TWO;
        row_d  = row_q + RW'(1);
        if (&row_q) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_d   = ST_EXP_S;
        end
      end
      ST_EXP_S: begin
        a_d = s_new;
        if (!pass_q[0]) begin
          odd_d  = ram_rdata[2*WW-1:WW];
          even_d = s_new;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pass_q[RW:1];
          ram_wdata = {s_new, even_q};
        end
        state_d = ST_EXP_L;
      end
      ST_EXP_L: begin
        kw_d[pass_q[1:0]] = l_new;
        b_d               = l_new;
        pass_d            = pass_q + PW'(1);
        if (pass_q == PW'(rc5_pkg::PASSES - 1)) begin
          sched_valid_d = 1'b1;
          a_d           = '0;
          b_d           = '0;
          state_d       = ST_FINISH;
        end else begin
          if (pass_q[0]) begin
            ram_re    = 1'b1;
            ram_raddr = pass_q[RW:1] + RW'(1);
          end
          state_d = ST_EXP_S;
        end
      end
      ST_CRYPT: begin
        a_d = rnd_a;
        b_d = rnd_b;
        if (cnt_q == CNT_W'(ROUNDS)) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d     = cnt_next;
          ram_re    = 1'b1;
          ram_raddr = dec_q ? RW'(CNT_W'(ROUNDS) - cnt_next) : RW'(cnt_next);
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          res_a_d     = a_q;
          res_b_d     = b_q;
          res_stat_d  = stat_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      sched_valid_q <= 1'b0;
      res_a_q       <= '0;
      res_b_q       <= '0;
      res_stat_q    <= 1'b0;
      key_low_q     <= '0;
      key_high_q    <= '0;
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      sched_valid_q <= sched_valid_d;
      res_a_q       <= res_a_d;
      res_b_q       <= res_b_d;
      res_stat_q    <= res_stat_d;
      if (cfg_valid_i && cfg_index_i == rc5_pkg::CFG_KEY_LOW) begin
        key_low_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == rc5_pkg::CFG_KEY_HIGH) begin
        key_high_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    even_q <= even_d;
    odd_q  <= odd_d;
    kw_q   <= kw_d;
    row_q  <= row_d;
    pass_q <= pass_d;
    cnt_q  <= cnt_d;
    dec_q  <= dec_d;
    stat_q <= stat_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign result_a_o  = res_a_q;
  assign result_b_o  = res_b_q;
  assign status_o    = res_stat_q;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("core took a request while busy");

  a_status_zero_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> result_a_o == '0 && result_b_o == '0)
    else $error("error status with nonzero result words");

  a_expand_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXP_L && pass_q == PW'(rc5_pkg::PASSES - 1) |=> sched_valid_q)
    else $error("schedule not marked valid after expand");

  a_no_write_in_crypt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CRYPT |-> !ram_we)
    else $error("round key RAM written during a cipher pass");

endmodule

/* bench/tb_rc5_block_cipher.sv */
module tb_rc5_block_cipher;

  localparam int unsigned    CIPHER_ROUNDS = 15;
  localparam int unsigned    IDLE_LIMIT    = 4000;
  localparam int unsigned    DRAIN_CYCLES  = 250;
  localparam int unsigned    PHASE_ITEMS   = 305;
  localparam rc5_pkg::cmd_t  CMD_UNUSED    = 2'd3;

  typedef struct packed {
    rc5_pkg::word_t a;
    rc5_pkg::word_t b;
    logic           status;
  } block_result_t;

  class cipher_scoreboard;
    localparam rc5_pkg::word_t SEED_P = 32'hb7e15163;
    localparam rc5_pkg::word_t SEED_Q = 32'h9e3779b9;

    rc5_pkg::word_t           round_key [32];
    rc5_pkg::word_t           key_word [4];
    bit                       have_schedule;
    logic [rc5_pkg::KEY_W-1:0] key_low;
    logic [rc5_pkg::KEY_W-1:0] key_high;
    block_result_t            expected_q [$];
    int                       errors;
    int                       checked;

    function new();
      have_schedule = 1'b0;
      key_low       = '0;
      key_high      = '0;
      errors        = 0;
      checked       = 0;
    endfunction

    function rc5_pkg::word_t rol(input rc5_pkg::word_t x, input logic [4:0] s);
      if (s == 0) return x;
      return (x << s) | (x >> (6'd32 - s));
    endfunction

    function rc5_pkg::word_t ror(input rc5_pkg::word_t x, input logic [4:0] s);
      if (s == 0) return x;
      return (x >> s) | (x << (6'd32 - s));
    endfunction

    function rc5_pkg::word_t rk(input int unsigned idx);
      return round_key[idx % 32];
    endfunction

    function void set_key(input logic [rc5_pkg::CFG_IDX_W-1:0] index,
                          input logic [rc5_pkg::KEY_W-1:0] data);
      if (index == rc5_pkg::CFG_KEY_LOW) key_low = data;
      else if (index == rc5_pkg::CFG_KEY_HIGH) key_high = data;
    endfunction

    function void expand_schedule();
      rc5_pkg::word_t x;
      rc5_pkg::word_t y;
      rc5_pkg::word_t sum;
      int unsigned    i;
      int unsigned    j;
      x = '0;
      y = '0;
      i = 0;
      j = 0;
      for (int n = 0; n < 32; n++) round_key[n] = SEED_P + rc5_pkg::word_t'(n) * SEED_Q;
      key_word[0] = key_low[31:0];
      key_word[1] = key_low[63:32];
      key_word[2] = key_high[31:0];
      key_word[3] = key_high[63:32];
      for (int n = 0; n < 96; n++) begin
        round_key[i] = rol(round_key[i] + x + y, 5'd3);
        x = round_key[i];
        sum = x + y;
        key_word[j] = rol(key_word[j] + sum, sum[4:0]);
        y = key_word[j];
        i = (i + 1) % 32;
        j = (j + 1) % 4;
      end
      have_schedule = 1'b1;
    endfunction

    function block_result_t note_request(input rc5_pkg::cmd_t cmd, input rc5_pkg::word_t a_in,
                                         input rc5_pkg::word_t b_in);
      block_result_t  res;
      rc5_pkg::word_t a;
      rc5_pkg::word_t b;
      res = '0;
      a   = a_in;
      b   = b_in;
      if (cmd == rc5_pkg::CMD_EXPAND) begin
        expand_schedule();
      end else if (cmd == rc5_pkg::CMD_ENCRYPT || cmd == rc5_pkg::CMD_DECRYPT) begin
        if (!have_schedule) begin
          res.status = 1'b1;
        end else if (cmd == rc5_pkg::CMD_ENCRYPT) begin
          a = a + rk(0);
          b = b + rk(1);
          for (int unsigned r = 1; r <= CIPHER_ROUNDS; r++) begin
            a = rol(a ^ b, b[4:0]) + rk(2 * r);
            b = rol(a ^ b, a[4:0]) + rk(2 * r + 1);
          end
          res.a = a;
          res.b = b;
        end else begin
          for (int unsigned r = CIPHER_ROUNDS; r > 0; r--) begin
            b = ror(b - rk(2 * r + 1), a[4:0]) ^ a;
            a = ror(a - rk(2 * r), b[4:0]) ^ b;
          end
          res.a = a - rk(0);
          res.b = b - rk(1);
        end
      end
      expected_q.push_back(res);
      return res;
    endfunction

    task report_error(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(input rc5_pkg::word_t a, input rc5_pkg::word_t b, input logic status);
      block_result_t exp_res;
      if (expected_q.size() == 0) begin
        report_error($sformatf("unexpected result a=%h b=%h status=%b", a, b, status));
      end else begin
        exp_res = expected_q.pop_front();
        checked++;
        if (a !== exp_res.a)
          report_error($sformatf("result_a %h, want %h", a, exp_res.a));
        if (b !== exp_res.b)
          report_error($sformatf("result_b %h, want %h", b, exp_res.b));
        if (status !== exp_res.status)
          report_error($sformatf("status %b, want %b", status, exp_res.status));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  rc5_pkg::cmd_t                 command_i   = rc5_pkg::CMD_EXPAND;
  rc5_pkg::word_t                word_a_i    = '0;
  rc5_pkg::word_t                word_b_i    = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  rc5_pkg::word_t                result_a_o;
  rc5_pkg::word_t                result_b_o;
  logic                          status_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [rc5_pkg::CFG_IDX_W-1:0] cfg_index_i = rc5_pkg::CFG_KEY_LOW;
  logic [rc5_pkg::KEY_W-1:0]     cfg_data_i  = '0;

  cipher_scoreboard sb;

  bit             steady;
  int             rx_hold;
  int             idle_cycles;
  int             sent;
  int             expands;
  int             key_writes;
  rc5_pkg::word_t last_a;
  rc5_pkg::word_t last_b;

  rc5_block_cipher #(
    .ROUNDS(CIPHER_ROUNDS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .word_a_i   (word_a_i),
    .word_b_i   (word_b_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_a_o (result_a_o),
    .result_b_o (result_b_o),
    .status_o   (status_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rc5_pkg::word_t pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (steady) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= draw_gap();
    end else begin
      out_ready_i <= 1'b1;
      rx_hold     <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(result_a_o, result_b_o, status_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("rc5_block_cipher: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input rc5_pkg::cmd_t cmd, input rc5_pkg::word_t a,
                              input rc5_pkg::word_t b);
    int            gap;
    block_result_t res;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    word_a_i   <= a;
    word_b_i   <= b;
    do @(posedge clk_i); while (!in_ready_o);
    res = sb.note_request(cmd, a, b);
    sent++;
    if (cmd == rc5_pkg::CMD_EXPAND) expands++;
    if (cmd == rc5_pkg::CMD_ENCRYPT && !res.status) begin
      last_a = res.a;
      last_b = res.b;
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_key(input logic [rc5_pkg::CFG_IDX_W-1:0] index,
                           input logic [rc5_pkg::KEY_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_key(index, data);
    key_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [rc5_pkg::KEY_W-1:0] k_low,
                           input logic [rc5_pkg::KEY_W-1:0] k_high);
    int             r;
    rc5_pkg::word_t a;
    rc5_pkg::word_t b;
    wait_idle();
    write_key(rc5_pkg::CFG_KEY_LOW, k_low);
    write_key(rc5_pkg::CFG_KEY_HIGH, k_high);
    if ($urandom_range(0, 4) != 0) send_request(rc5_pkg::CMD_EXPAND, pick_word(), pick_word());
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      a = pick_word();
      b = pick_word();
      if (r < 3) begin
        send_request(rc5_pkg::CMD_EXPAND, a, b);
      end else if (r < 6) begin
        send_request(CMD_UNUSED, a, b);
      end else if (r < 50) begin
        send_request(rc5_pkg::CMD_ENCRYPT, a, b);
      end else if (r < 75) begin
        send_request(rc5_pkg::CMD_DECRYPT, last_a, last_b);
      end else begin
        send_request(rc5_pkg::CMD_DECRYPT, a, b);
      end
    end
  endtask

  initial begin
    sb         = new();
    steady     = 1'b0;
    rx_hold    = 0;
    idle_cycles = 0;
    sent       = 0;
    expands    = 0;
    key_writes = 0;
    last_a     = '0;
    last_b     = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(rc5_pkg::CMD_ENCRYPT, '0, '0);
    send_request(rc5_pkg::CMD_DECRYPT, '1, '1);
    send_request(CMD_UNUSED, $urandom, $urandom);
    send_request(rc5_pkg::CMD_EXPAND, $urandom, $urandom);
    send_request(rc5_pkg::CMD_ENCRYPT, '0, '0);
    send_request(rc5_pkg::CMD_ENCRYPT, '1, '1);
    send_request(rc5_pkg::CMD_DECRYPT, '0, '0);
    send_request(rc5_pkg::CMD_DECRYPT, '1, '1);
    send_request(rc5_pkg::CMD_ENCRYPT, 32'h0000_0001, 32'h8000_0000);
    send_request(rc5_pkg::CMD_DECRYPT, last_a, last_b);
    send_request(CMD_UNUSED, '1, '1);
    wait_idle();
    write_key(rc5_pkg::CFG_KEY_LOW, '1);
    write_key(rc5_pkg::CFG_KEY_HIGH, '1);
    send_request(rc5_pkg::CMD_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
    send_request(rc5_pkg::CMD_EXPAND, '1, '1);
    send_request(rc5_pkg::CMD_ENCRYPT, '0, '0);
    send_request(rc5_pkg::CMD_DECRYPT, '1, '1);
    send_request(rc5_pkg::CMD_ENCRYPT, $urandom, $urandom);
    send_request(rc5_pkg::CMD_DECRYPT, last_a, last_b);

    run_phase('0, '1);
    run_phase({$urandom, $urandom}, '0);
    steady = 1'b1;
    run_phase({$urandom, $urandom}, {$urandom, $urandom});
    steady = 1'b0;
    run_phase(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    run_phase({$urandom, $urandom}, {$urandom, $urandom});
    run_phase(64'h8000_0000_0000_0001, {$urandom, $urandom});

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d requests (%0d expands) under %0d key writes", sent, expands,
             key_writes);
    $display("%0d results compared, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("rc5_block_cipher: match");
    end else begin
      $display("rc5_block_cipher: mismatch");
    end
    $finish;
  end

endmodule
